### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent check on clk, masked while rst is high
`define LWP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// concurrent check on clk that also holds during reset
`define LWP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### design/lwp_pkg.sv
`timescale 1ns / 1ps
package lwp_pkg;

  localparam int MAX_SAMPLES = 16384;
  localparam int SAMPLE_BITS = 32;
  localparam int CNT_W       = $clog2(MAX_SAMPLES) + 1;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int SUM_W       = SAMPLE_BITS + ADDR_W;
  localparam int BIT_W       = $clog2(SAMPLE_BITS);
  localparam int LEN_W       = 15;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(10000);
  localparam logic [1:0]       ADDR_WINDOW_LENGTH = 2'd0;

  // reciprocal constants for divide by 10 and 100, exact for the count range
  localparam int RECIP_SHIFT = 22;
  localparam logic [31:0] RECIP10  = 32'((64'd1 << RECIP_SHIFT) / 10 + 1);
  localparam logic [31:0] RECIP100 = 32'((64'd1 << RECIP_SHIFT) / 100 + 1);

  typedef struct packed {
    logic                start;
    logic [CNT_W-1:0]    n;
    logic [ADDR_W-1:0]   k_a;
    logic [ADDR_W-1:0]   k_b;
  } sel_ctrl_t;

  // n - ceil(n/10)
  function automatic logic [ADDR_W-1:0] idx_p90(input logic [CNT_W-1:0] n);
    logic [63:0] prod;
    logic [CNT_W-1:0] q;
    prod = 64'(n + CNT_W'(9)) * 64'(RECIP10);
    q = CNT_W'(prod >> RECIP_SHIFT);
    return ADDR_W'(n - q);
  endfunction

  // n - ceil(n/100)
  function automatic logic [ADDR_W-1:0] idx_p99(input logic [CNT_W-1:0] n);
    logic [63:0] prod;
    logic [CNT_W-1:0] q;
    prod = 64'({1'b0, n} + (CNT_W+1)'(99)) * 64'(RECIP100);
    q = CNT_W'(prod >> RECIP_SHIFT);
    return ADDR_W'(n - q);
  endfunction

endpackage

### design/latency_window_percentiles_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Windowed latency statistics. Each sample transfer on the s_ side is written
// to a 16384 x 32 sample RAM while min, max and sum are kept on the fly. When
// the sample count reaches window_length (0 acts as 1, above 16384 acts as
// 16384) the input stalls while the p90 and p99 values are found by a
// bit-by-bit search: 32 sweeps over the window through the RAM's single read
// port. s_tready stays low from the last sample of a window until its result
// is loaded into the output register. The average comes from a shift-subtract
// divider running alongside, which always ends before the search. One result
// transfer on the m_ side per window; it sits in an output register, so
// collection of the next window goes on while it waits.
module latency_window_percentiles_top (
  input  logic         clk,
  input  logic         rst,
  // apb configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // sample stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [31:0] latency_ns
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata    // min_ns, p90_ns, p99_ns, max_ns, avg_ns (32 bits each)
);
  import lwp_pkg::*;

  typedef enum logic [2:0] {
    S_COLLECT,
    S_INDEX,
    S_LAUNCH,
    S_RUN,
    S_OUT
  } state_t;

  state_t                 state;
  logic [LEN_W-1:0]       window_length;
  logic [CNT_W-1:0]       len_eff;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [SUM_W-1:0]       sum;
  logic [SAMPLE_BITS-1:0] min_v;
  logic [SAMPLE_BITS-1:0] max_v;
  logic [CNT_W-1:0]       n_r;
  logic [ADDR_W-1:0]      k90;
  logic [ADDR_W-1:0]      k99;
  logic                   sel_fin;
  logic                   div_fin;
  logic                   in_xfer;
  logic                   cfg_wr;
  sel_ctrl_t              sel_ctrl;
  logic                   rd_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   sel_done;
  logic [SAMPLE_BITS-1:0] p90_v;
  logic [SAMPLE_BITS-1:0] p99_v;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] avg_v;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_WINDOW_LENGTH);
  assign prdata = (paddr == ADDR_WINDOW_LENGTH) ? 32'(window_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_RESET;
    end else if (cfg_wr) begin
      window_length <= pwdata[LEN_W-1:0];
    end
  end

  // effective window length
  always_comb begin
    if (window_length == '0) begin
      len_eff = CNT_W'(1);
    end else if (CNT_W'(window_length) > CNT_W'(MAX_SAMPLES)) begin
      len_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      len_eff = CNT_W'(window_length);
    end
  end

  assign s_tready   = (state == S_COLLECT);
  assign in_xfer    = s_tvalid && s_tready;
  assign count_next = count + CNT_W'(1);

  // sample memory
  lwp_ram #(
    .DEPTH(MAX_SAMPLES),
    .WIDTH(SAMPLE_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (in_xfer),
    .waddr(count[ADDR_W-1:0]),
    .wdata(s_tdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign sel_ctrl.start = (state == S_LAUNCH);
  assign sel_ctrl.n     = n_r;
  assign sel_ctrl.k_a   = k90;
  assign sel_ctrl.k_b   = k99;

  lwp_select u_select (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (sel_ctrl),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .done   (sel_done),
    .val_a  (p90_v),
    .val_b  (p99_v)
  );

  lwp_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (sel_ctrl.start),
    .dividend(sum),
    .divisor (n_r),
    .done    (div_done),
    .quotient(avg_v)
  );

  // window control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_COLLECT;
      count    <= '0;
      sum      <= '0;
      sel_fin  <= 1'b0;
      div_fin  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (sel_done) begin
        sel_fin <= 1'b1;
      end
      if (div_done) begin
        div_fin <= 1'b1;
      end
      case (state)
        S_COLLECT: begin
          if (in_xfer) begin
            count <= count_next;
            sum   <= sum + SUM_W'(s_tdata);
            if (count == '0 || s_tdata < min_v) begin
              min_v <= s_tdata;
            end
            if (count == '0 || s_tdata > max_v) begin
              max_v <= s_tdata;
            end
            if (count_next >= len_eff) begin
              n_r   <= count_next;
              state <= S_INDEX;
            end
          end
        end
        S_INDEX: begin
          k90   <= idx_p90(n_r);
          k99   <= idx_p99(n_r);
          state <= S_LAUNCH;
        end
        S_LAUNCH: begin
          sel_fin <= 1'b0;
          div_fin <= 1'b0;
          state   <= S_RUN;
        end
        S_RUN: begin
          if (sel_fin && div_fin) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {avg_v, max_v, p99_v, p90_v, min_v};
            count    <= '0;
            sum      <= '0;
            state    <= S_COLLECT;
          end
        end
        default: begin
          state <= S_COLLECT;
        end
      endcase
    end
  end

  `LWP_ASSERT(a_top_count_rng, count <= CNT_W'(MAX_SAMPLES), "sample count past memory")
  `LWP_ASSERT(a_top_launch, state == S_LAUNCH |=> state == S_RUN && u_select.busy == 1'b1,
              "search did not start")
  `LWP_ASSERT(a_top_window_full, state == S_INDEX |-> n_r >= CNT_W'(1) && n_r == count,
              "window closed with bad count")

endmodule

### design/lwp_ram.sv
`timescale 1ns / 1ps
module lwp_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/lwp_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lwp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lwp_pkg::SUM_W-1:0]   dividend,
  input  logic [lwp_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [lwp_pkg::SAMPLE_BITS-1:0] quotient
);
  import lwp_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    trial;
  logic              fits;

  // one quotient bit per cycle
  assign trial = {rem, quo[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign quotient = quo[SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(SUM_W - 1);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        quo <= {quo[SUM_W-2:0], fits};
        rem <= fits ? CNT_W'(trial - {1'b0, dvs}) : CNT_W'(trial);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - STEP_W'(1);
        end
      end
    end
  end

  `LWP_ASSERT(a_div_done_from_busy, done |-> $past(busy), "divider done without a run")
  `LWP_ASSERT(a_div_rem_lt, busy && !start && step != '0 |-> rem < dvs,
              "divider remainder out of range")
  `LWP_ASSERT(a_div_step_rng, busy |-> step < STEP_W'(SUM_W), "divider step out of range")

endmodule

### design/lwp_select.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lwp_select (
  input  logic                            clk,
  input  logic                            rst,
  input  lwp_pkg::sel_ctrl_t              ctrl,
  output logic                            rd_en,
  output logic [lwp_pkg::ADDR_W-1:0]      rd_addr,
  input  logic [lwp_pkg::SAMPLE_BITS-1:0] rd_data,
  output logic                            done,
  output logic [lwp_pkg::SAMPLE_BITS-1:0] val_a,
  output logic [lwp_pkg::SAMPLE_BITS-1:0] val_b
);
  import lwp_pkg::*;

  logic                   busy;
  logic [BIT_W-1:0]       bit_idx;
  logic [CNT_W-1:0]       addr;
  logic [CNT_W-1:0]       n_r;
  logic [ADDR_W-1:0]      k_a;
  logic [ADDR_W-1:0]      k_b;
  logic                   dv;
  logic                   dlast;
  logic [CNT_W-1:0]       cnt_a;
  logic [CNT_W-1:0]       cnt_b;
  logic [SAMPLE_BITS-1:0] pre_a;
  logic [SAMPLE_BITS-1:0] pre_b;
  logic [SAMPLE_BITS-1:0] bit_mask;
  logic [SAMPLE_BITS-1:0] low_mask;
  logic                   hit_a;
  logic                   hit_b;
  logic [CNT_W-1:0]       tot_a;
  logic [CNT_W-1:0]       tot_b;
  logic                   issue;

  // sweep addresses over the window, data back in the next cycle
  assign issue   = busy && (addr < n_r);
  assign rd_en   = issue;
  assign rd_addr = addr[ADDR_W-1:0];

  // count samples at or below each trial bound
  assign bit_mask = SAMPLE_BITS'(1) << bit_idx;
  assign low_mask = bit_mask - SAMPLE_BITS'(1);
  assign hit_a    = dv && (rd_data <= (pre_a | low_mask));
  assign hit_b    = dv && (rd_data <= (pre_b | low_mask));
  assign tot_a    = cnt_a + CNT_W'(hit_a);
  assign tot_b    = cnt_b + CNT_W'(hit_b);
  assign val_a    = pre_a;
  assign val_b    = pre_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      dv    <= 1'b0;
      dlast <= 1'b0;
    end else begin
      done  <= 1'b0;
      dv    <= issue;
      dlast <= issue && (addr == n_r - CNT_W'(1));
      if (ctrl.start) begin
        busy    <= 1'b1;
        bit_idx <= BIT_W'(SAMPLE_BITS - 1);
        addr    <= '0;
        n_r     <= ctrl.n;
        k_a     <= ctrl.k_a;
        k_b     <= ctrl.k_b;
        cnt_a   <= '0;
        cnt_b   <= '0;
        pre_a   <= '0;
        pre_b   <= '0;
      end else if (busy) begin
        if (issue) begin
          addr <= addr + CNT_W'(1);
        end
        if (dv) begin
          cnt_a <= tot_a;
          cnt_b <= tot_b;
        end
        // end of a sweep: settle one value bit of each result
        if (dlast) begin
          if (!(tot_a > CNT_W'(k_a))) begin
            pre_a <= pre_a | bit_mask;
          end
          if (!(tot_b > CNT_W'(k_b))) begin
            pre_b <= pre_b | bit_mask;
          end
          cnt_a <= '0;
          cnt_b <= '0;
          addr  <= '0;
          if (bit_idx == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            bit_idx <= bit_idx - BIT_W'(1);
          end
        end
      end
    end
  end

  `LWP_ASSERT(a_sel_done_last, done |-> $past(dlast) && $past(bit_idx) == '0,
              "select done before the last sweep")
  `LWP_ASSERT(a_sel_addr_rng, busy |-> addr <= n_r, "select address past window")
  `LWP_ASSERT(a_sel_cnt_rng, busy |-> cnt_a <= n_r && cnt_b <= n_r,
              "select count exceeds window")

endmodule
